// ===== hw/rtl/tssm_pkg.sv =====
// Shared types and constants for the three-stacks-in-one-memory block.
package tssm_pkg;

    localparam int NUM_STACKS = 3;
    localparam int MAX_DEPTH  = 256;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MEM_DEPTH  = NUM_STACKS * MAX_DEPTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int MODE_W     = 2;
    localparam int SEL_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic load_rdata;
    } cmd_t;

    typedef struct packed {
        logic needs_read;
    } status_t;

endpackage

// ===== hw/rtl/triple_stack_shared_memory.sv =====
// Top level: three stacks sharing one interleaved memory, streaming interface.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  s_tdata: mode, stack_sel, write_value
//  m_*       out        m_tvalid/m_tready  m_tdata: read_value, was_empty, push_dropped
//  cfg_*     in         cfg_wr_en          cfg_wr_data: stack_limit
//
// One item is handled at a time. A push, or an operation on an empty stack
// or on selector 3, goes from the execute state straight to the output
// state; a pop or peek that reads memory first passes the read wait state,
// which covers the registered read of the single memory port. Reset clears
// the entry counters and sets stack_limit to 256; the memory is not
// cleared, since a word is only read after it was written.
// A stalled output holds the result and the block takes no new input until
// the result transfer completes.
module triple_stack_shared_memory (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0 up: mode[1:0], stack_sel[3:2], write_value[35:4], zero pad.
    input  logic [tssm_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0 up: read_value[31:0], was_empty[32], push_dropped[33], zero pad.
    output logic [tssm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [tssm_pkg::CNT_W-1:0]        cfg_wr_data
);
    import tssm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller steps through accept, execute, optional read wait and output.
    tssm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // The datapath holds the counters, the shared memory and the result register.
    tssm_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_tdata    (s_tdata),
        .out_tdata   (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== hw/rtl/tssm_ram.sv =====
// Generic single-port RAM with registered read data.
module tssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tssm_ctrl.sv =====
// Controller state machine that sequences one stack operation at a time.
module tssm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output tssm_pkg::cmd_t    cmd,
    input  tssm_pkg::status_t status
);
    import tssm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = status.needs_read ? ST_READ : ST_OUT;
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        cmd.latch_in   = 1'b0;
        cmd.exec       = 1'b0;
        cmd.load_rdata = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_READ:
            begin
                cmd.load_rdata = 1'b1;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // An accepted item is always executed in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted item was not executed next cycle");

    // The read wait state is entered only when execution asked for memory data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && !status.needs_read) |=> (state_reg == ST_OUT))
        else $error("read wait entered without a memory read");

    // A result is held until the consumer takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped before transfer");

endmodule

// ===== hw/rtl/tssm_dpath.sv =====
// Datapath: item registers, entry counters, limit register, memory and result registers.
module tssm_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tssm_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic [tssm_pkg::IN_TDATA_W-1:0]   in_tdata,
    output logic [tssm_pkg::OUT_TDATA_W-1:0]  out_tdata,
    input  tssm_pkg::cmd_t                    cmd,
    output tssm_pkg::status_t                 status
);
    import tssm_pkg::*;

    logic [MODE_W-1:0]  mode_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic [DATA_W-1:0]  wval_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic [CNT_W-1:0]   count_reg [NUM_STACKS];
    logic [DATA_W-1:0]  rval_reg;
    logic               empty_reg;
    logic               dropped_reg;

    logic               sel_ok;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   eff_limit;
    logic               is_push;
    logic               full;
    logic               do_write;
    logic               do_read;
    logic               do_pop;
    logic [IDX_W-1:0]   slot;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg <= in_tdata[MODE_W-1:0];
            sel_reg  <= in_tdata[MODE_W+SEL_W-1:MODE_W];
            wval_reg <= in_tdata[MODE_W+SEL_W+DATA_W-1:MODE_W+SEL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= CNT_W'(MAX_DEPTH);
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    assign sel_ok    = (sel_reg < SEL_W'(NUM_STACKS));
    assign cnt       = sel_ok ? count_reg[sel_reg] : '0;
    assign cnt_m1    = cnt - CNT_W'(1);
    assign eff_limit = (limit_reg > CNT_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH) : limit_reg;
    assign is_push   = (mode_reg == MODE_PUSH);
    assign full      = (cnt >= eff_limit) || (cnt >= CNT_W'(MAX_DEPTH));
    assign do_write  = sel_ok && is_push && !full;
    assign do_read   = sel_ok && !is_push && (cnt != '0);
    assign do_pop    = do_read && (mode_reg == MODE_POP);

    // Entry i of stack k sits in word 3*i+k.
    assign slot = is_push ? cnt[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
    assign addr = ADDR_W'(slot) * ADDR_W'(NUM_STACKS) + ADDR_W'(sel_reg);

    assign status.needs_read = do_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_STACKS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (do_write)
            begin
                count_reg[sel_reg] <= cnt + CNT_W'(1);
            end
            else if (do_pop)
            begin
                count_reg[sel_reg] <= cnt_m1;
            end
        end
    end

    tssm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (cmd.exec && (do_write || do_read)),
        .we    (do_write),
        .addr  (addr),
        .wdata (wval_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rval_reg    <= is_push ? '0 : '1;
            empty_reg   <= sel_ok ? (cnt == '0) : 1'b1;
            dropped_reg <= is_push && (!sel_ok || full);
        end
        else if (cmd.load_rdata)
        begin
            rval_reg <= rdata;
        end
    end

    assign out_tdata = {(OUT_TDATA_W-DATA_W-2)'(0), dropped_reg, empty_reg, rval_reg};

    // No stack ever holds more than the memory slice reserved for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[0] <= CNT_W'(MAX_DEPTH)) && (count_reg[1] <= CNT_W'(MAX_DEPTH))
        && (count_reg[2] <= CNT_W'(MAX_DEPTH)))
        else $error("stack entry count above depth");

    // Memory is never written and read for the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !(do_write && do_read))
        else $error("write and read requested together");

endmodule
